>>> hdl/gcd_pkg.sv
// Shared types, constants and the CORDIC angle table for the great-circle
// distance pipeline. No dependencies.
package gcd_pkg;

    localparam int CORDIC_STAGES = 30;
    localparam int SQRT_STAGES   = 32;

    localparam logic [63:0] PI_Q62       = 64'hC90FDAA22168C235;
    localparam logic [63:0] RAD_SCALE_64 = ((PI_Q62 >> 1) + 64'd900000000) / 64'd1800000000;
    localparam logic [31:0] RAD_SCALE    = RAD_SCALE_64[31:0];

    localparam logic [32:0] INV_GAIN    = 33'd652032874;
    localparam logic [32:0] PI_Q30      = 33'd3373259426;
    localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
    localparam logic [22:0] EARTH_R_M   = 23'd6372795;
    localparam logic [24:0] HALF_CIRC_M = 25'd20020726;

    // rotation-mode CORDIC state (sine/cosine lanes)
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } t_rot_st;

    // bitwise root state
    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } t_sqrt_st;

    // vectoring-mode CORDIC state (atan2)
    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [33:0] z;
    } t_vec_st;

    // atan(2^-i) in radians, 30 fraction bits
    function automatic logic [29:0] stage_angle(input int i);
        logic [29:0] a;
        case (i)
            0:       a = 30'd843314857;
            1:       a = 30'd497837829;
            2:       a = 30'd263043837;
            3:       a = 30'd133525159;
            4:       a = 30'd67021687;
            5:       a = 30'd33543516;
            6:       a = 30'd16775851;
            7:       a = 30'd8388437;
            8:       a = 30'd4194283;
            9:       a = 30'd2097149;
            10:      a = 30'd1048576;
            default: a = 30'd1 << (30 - i);
        endcase
        return a;
    endfunction

endpackage

>>> hdl/gcd_rot_cell.sv
// One rotation-mode CORDIC cell: a micro-rotation by atan(2^-STAGE).
// Depends on gcd_pkg.
module gcd_rot_cell
    import gcd_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_rot_st          i_st,
    input  logic [TAG_W-1:0] i_tag,
    output t_rot_st          o_st,
    output logic [TAG_W-1:0] o_tag
);

    localparam logic signed [32:0] ANG = $signed({3'b000, stage_angle(STAGE)});

    t_rot_st n_st;
    t_rot_st r_st;
    logic [TAG_W-1:0] r_tag;

    always_comb begin
        if (!i_st.z[32]) begin
            n_st.x = i_st.x - (i_st.y >>> STAGE);
            n_st.y = i_st.y + (i_st.x >>> STAGE);
            n_st.z = i_st.z - ANG;
        end else begin
            n_st.x = i_st.x + (i_st.y >>> STAGE);
            n_st.y = i_st.y - (i_st.x >>> STAGE);
            n_st.z = i_st.z + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st  <= n_st;
            r_tag <= i_tag;
        end
    end

    assign o_st  = r_st;
    assign o_tag = r_tag;

endmodule

>>> hdl/gcd_sqrt_cell.sv
// One digit of the bitwise integer square root.
// Depends on gcd_pkg.
module gcd_sqrt_cell
    import gcd_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int TAG_W = 34
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_sqrt_st         i_st,
    input  logic [TAG_W-1:0] i_tag,
    output t_sqrt_st         o_st,
    output logic [TAG_W-1:0] o_tag
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STAGE);

    logic [63:0] w_trial;
    t_sqrt_st n_st;
    t_sqrt_st r_st;
    logic [TAG_W-1:0] r_tag;

    assign w_trial = i_st.res + BIT;

    always_comb begin
        if (i_st.v >= w_trial) begin
            n_st.v   = i_st.v - w_trial;
            n_st.res = (i_st.res >> 1) + BIT;
        end else begin
            n_st.v   = i_st.v;
            n_st.res = i_st.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st  <= n_st;
            r_tag <= i_tag;
        end
    end

    assign o_st  = r_st;
    assign o_tag = r_tag;

endmodule

>>> hdl/gcd_vec_cell.sv
// One vectoring-mode CORDIC cell for atan2: drive y toward zero.
// Depends on gcd_pkg.
module gcd_vec_cell
    import gcd_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int TAG_W = 2
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_vec_st          i_st,
    input  logic [TAG_W-1:0] i_tag,
    output t_vec_st          o_st,
    output logic [TAG_W-1:0] o_tag
);

    localparam logic signed [33:0] ANG = $signed({4'b0000, stage_angle(STAGE)});

    t_vec_st n_st;
    t_vec_st r_st;
    logic [TAG_W-1:0] r_tag;

    always_comb begin
        if (!i_st.y[35] && (i_st.y != '0)) begin
            n_st.x = i_st.x + (i_st.y >>> STAGE);
            n_st.y = i_st.y - (i_st.x >>> STAGE);
            n_st.z = i_st.z + ANG;
        end else begin
            n_st.x = i_st.x - (i_st.y >>> STAGE);
            n_st.y = i_st.y + (i_st.x >>> STAGE);
            n_st.z = i_st.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st  <= n_st;
            r_tag <= i_tag;
        end
    end

    assign o_st  = r_st;
    assign o_tag = r_tag;

endmodule

>>> hdl/great_circle_distance.sv
// Top level of the great-circle distance pipeline.
// Depends on gcd_pkg, gcd_rot_cell, gcd_sqrt_cell, gcd_vec_cell.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    i_lat_a, i_lon_a, i_lat_b, i_lon_b
//   output    out        o_out_valid / i_out_ready  o_distance_m
//
// One beat in per cycle and one beat out per cycle while the output register is
// not stalled; the depth is set by the three chains of cells (sine/cosine, root,
// atan2), each cell one register stage.
// Reset clears only the valid bits of the pipeline; data registers hold junk.
// The whole pipeline advances together; it holds only while the output
// register holds a beat that the downstream side does not take.
module great_circle_distance
    import gcd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [30:0] i_lat_a,
    input  logic signed [31:0] i_lon_a,
    input  logic signed [30:0] i_lat_b,
    input  logic signed [31:0] i_lon_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [24:0]        o_distance_m
);

    localparam int PIPE_DEPTH = 12 + 2 * CORDIC_STAGES + SQRT_STAGES;

    // round-half-up fixed-point product, 30 fraction bits
    function automatic logic signed [32:0] qmul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        p = p + 66'sd536870912;
        return 33'(p >>> 30);
    endfunction

    logic w_en;
    logic [PIPE_DEPTH-1:0] r_vld;

    // advance whenever the output register is empty or being drained
    assign w_en        = !r_vld[PIPE_DEPTH-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    // ---- input stage: capture latitudes, wrap the longitude difference once
    logic signed [32:0] n_dl;
    logic signed [30:0] r_la;
    logic signed [30:0] r_lb;
    logic signed [31:0] r_dl;

    always_comb begin
        n_dl = 33'(i_lon_a) - 33'(i_lon_b);
        if (n_dl > 33'sd1800000000) begin
            n_dl = n_dl - 33'sd3600000000;
        end else if (n_dl <= -33'sd1800000000) begin
            n_dl = n_dl + 33'sd3600000000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_la <= i_lat_a;
            r_lb <= i_lat_b;
            r_dl <= 32'(n_dl);
        end
    end

    // ---- three sine/cosine lanes: latitude a, latitude b, longitude difference
    logic signed [31:0] w_ang [3];
    t_rot_st            w_rot [3][CORDIC_STAGES+1];
    logic               w_rflip [3][CORDIC_STAGES+1];
    logic signed [32:0] r_sin [3];
    logic signed [32:0] r_cos [3];

    assign w_ang[0] = 32'(r_la);
    assign w_ang[1] = 32'(r_lb);
    assign w_ang[2] = r_dl;

    for (genvar j = 0; j < 3; j++) begin : g_lane
        logic signed [31:0] n_red;
        logic               n_flip;
        logic [29:0]        r_mag;
        logic               r_neg;
        logic               r_flip_r;
        logic [61:0]        w_prod;
        logic [30:0]        w_zmag;
        logic signed [32:0] r_z;
        logic               r_flip_z;

        // fold angles beyond a quarter turn, remember to negate the result
        always_comb begin
            n_red  = w_ang[j];
            n_flip = 1'b0;
            if (w_ang[j] > 32'sd900000000) begin
                n_red  = w_ang[j] - 32'sd1800000000;
                n_flip = 1'b1;
            end else if (w_ang[j] < -32'sd900000000) begin
                n_red  = w_ang[j] + 32'sd1800000000;
                n_flip = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_mag    <= n_red[31] ? 30'(-n_red) : 30'(n_red);
                r_neg    <= n_red[31];
                r_flip_r <= n_flip;
            end
        end

        // degrees*1e7 to radians with 30 fraction bits
        assign w_prod = 62'(r_mag) * 62'(RAD_SCALE);
        assign w_zmag = 31'((w_prod + (62'd1 << 30)) >> 31);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_z      <= r_neg ? -33'(w_zmag) : 33'(w_zmag);
                r_flip_z <= r_flip_r;
            end
        end

        assign w_rot[j][0].x  = $signed(INV_GAIN);
        assign w_rot[j][0].y  = '0;
        assign w_rot[j][0].z  = r_z;
        assign w_rflip[j][0]  = r_flip_z;

        for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
            gcd_rot_cell #(
                .STAGE (i),
                .TAG_W (1)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_st  (w_rot[j][i]),
                .i_tag (w_rflip[j][i]),
                .o_st  (w_rot[j][i+1]),
                .o_tag (w_rflip[j][i+1])
            );
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sin[j] <= w_rflip[j][CORDIC_STAGES] ? -w_rot[j][CORDIC_STAGES].y
                                                      : w_rot[j][CORDIC_STAGES].y;
                r_cos[j] <= w_rflip[j][CORDIC_STAGES] ? -w_rot[j][CORDIC_STAGES].x
                                                      : w_rot[j][CORDIC_STAGES].x;
            end
        end
    end

    // ---- cross and dot terms
    logic signed [32:0] r_c1s2, r_s1c2, r_t2, r_s1s2, r_c1c2, r_cd;
    logic signed [32:0] r_a, r_b, r_c1s2_2, r_t2_2, r_s1s2_2;
    logic signed [33:0] w_t1, w_den3;
    logic signed [33:0] r_den3, r_den4, r_den5;
    logic [33:0]        r_m1, r_m2;
    logic [67:0]        w_sq1, w_sq2;
    logic [63:0]        r_sq1, r_sq2, r_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1s2 <= qmul(r_cos[0], r_sin[1]);
            r_s1c2 <= qmul(r_sin[0], r_cos[1]);
            r_t2   <= qmul(r_cos[1], r_sin[2]);
            r_s1s2 <= qmul(r_sin[0], r_sin[1]);
            r_c1c2 <= qmul(r_cos[0], r_cos[1]);
            r_cd   <= r_cos[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a      <= qmul(r_s1c2, r_cd);
            r_b      <= qmul(r_c1c2, r_cd);
            r_c1s2_2 <= r_c1s2;
            r_t2_2   <= r_t2;
            r_s1s2_2 <= r_s1s2;
        end
    end

    assign w_t1   = 34'(r_c1s2_2) - 34'(r_a);
    assign w_den3 = 34'(r_s1s2_2) + 34'(r_b);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1   <= w_t1[33] ? 34'(-w_t1) : 34'(w_t1);
            r_m2   <= r_t2_2[32] ? 34'(-34'(r_t2_2)) : 34'(r_t2_2);
            r_den3 <= w_den3;
        end
    end

    assign w_sq1 = {34'd0, r_m1} * {34'd0, r_m1};
    assign w_sq2 = {34'd0, r_m2} * {34'd0, r_m2};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq1  <= w_sq1[63:0];
            r_sq2  <= w_sq2[63:0];
            r_den4 <= r_den3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v    <= r_sq1 + r_sq2;
            r_den5 <= r_den4;
        end
    end

    // ---- numerator root, one digit per cell; the dot term rides along
    t_sqrt_st    w_sq [SQRT_STAGES+1];
    logic [33:0] w_sden [SQRT_STAGES+1];

    assign w_sq[0].v   = r_v;
    assign w_sq[0].res = '0;
    assign w_sden[0]   = r_den5;

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        gcd_sqrt_cell #(
            .STAGE (k),
            .TAG_W (34)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_st  (w_sq[k]),
            .i_tag (w_sden[k]),
            .o_st  (w_sq[k+1]),
            .o_tag (w_sden[k+1])
        );
    end

    // ---- atan2 setup: pre-rotate by a quarter turn when the dot term is negative
    logic [32:0]        w_num;
    logic signed [33:0] w_den;
    logic               w_dneg;
    t_vec_st            r_vinit;
    logic [1:0]         r_vtag;

    assign w_num  = w_sq[SQRT_STAGES].res[32:0];
    assign w_den  = $signed(w_sden[SQRT_STAGES]);
    assign w_dneg = w_den[33];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vinit.x <= w_dneg ? $signed({3'b000, w_num}) : 36'(w_den);
            r_vinit.y <= w_dneg ? -36'(w_den) : $signed({3'b000, w_num});
            r_vinit.z <= w_dneg ? $signed(HALF_PI_Q30) : '0;
            r_vtag    <= {(w_num == '0), w_dneg};
        end
    end

    t_vec_st    w_vec [CORDIC_STAGES+1];
    logic [1:0] w_vtag [CORDIC_STAGES+1];

    assign w_vec[0]  = r_vinit;
    assign w_vtag[0] = r_vtag;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
        gcd_vec_cell #(
            .STAGE (i),
            .TAG_W (2)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_st  (w_vec[i]),
            .i_tag (w_vtag[i]),
            .o_st  (w_vec[i+1]),
            .o_tag (w_vtag[i+1])
        );
    end

    // ---- angle to metres: zero numerator means 0 or pi, clamp negatives and overlong results
    logic signed [33:0] w_z;
    logic [32:0]        n_ang;
    logic [55:0]        r_prod;
    logic [25:0]        w_dist;
    logic [24:0]        r_dist;

    assign w_z = w_vec[CORDIC_STAGES].z;

    always_comb begin
        if (w_vtag[CORDIC_STAGES][1]) begin
            n_ang = w_vtag[CORDIC_STAGES][0] ? PI_Q30 : '0;
        end else if (w_z[33]) begin
            n_ang = '0;
        end else begin
            n_ang = w_z[32:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= 56'(n_ang) * 56'(EARTH_R_M);
        end
    end

    assign w_dist = 26'((r_prod + (56'd1 << 29)) >> 30);

    // hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dist <= (w_dist > 26'(HALF_CIRC_M)) ? HALF_CIRC_M : w_dist[24:0];
        end
    end

    assign o_distance_m = r_dist;

endmodule

>>> test/gcd_checker.sv
`timescale 1ns / 100ps
// Checker for the great-circle distance pipeline: watches both channels, predicts the
// distance of every accepted input beat and compares it with the output beats.
// Depends on the port widths of great_circle_distance only.
module gcd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [30:0] i_lat_a,
    input  logic signed [31:0] i_lon_a,
    input  logic signed [30:0] i_lat_b,
    input  logic signed [31:0] i_lon_b,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [24:0]        i_distance_m,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam logic [63:0] PI_Q62     = 64'hC90FDAA22168C235;
    localparam longint      ARC_PI     = longint'((PI_Q62 + 64'h80000000) >> 32);
    localparam longint      ARC_HALFPI = longint'(((PI_Q62 >> 1) + 64'h80000000) >> 32);
    localparam logic [63:0] DEG_TO_RAD = ((PI_Q62 >> 1) + 64'd900000000) / 64'd1800000000;
    localparam longint      ROT_START  = 652032874;
    localparam int          N_STAGES   = 30;
    localparam logic [63:0] RADIUS_M   = 64'd6372795;
    localparam logic [63:0] HALF_EARTH = 64'd20020726;

    longint     atan_tab [N_STAGES];
    logic [24:0] distance_q [$];

    initial begin
        logic [63:0] acc;
        longint      sum;
        logic        neg;
        for (int i = 0; i < N_STAGES; i++) begin
            if (i == 0) begin
                acc = PI_Q62 >> 2;
            end else begin
                sum = 0;
                neg = 0;
                for (int n = 1; i * n <= 62; n += 2) begin
                    sum = neg ? sum - longint'((64'd1 << (62 - i * n)) / n)
                              : sum + longint'((64'd1 << (62 - i * n)) / n);
                    neg = !neg;
                end
                acc = sum;
            end
            atan_tab[i] = longint'((acc + 64'h80000000) >> 32);
        end
    end

    function automatic longint mul_q30(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    // rotation CORDIC on a degree value, folded into a quarter turn first
    function automatic void trig_of(input longint deg, output longint s, output longint c);
        logic        flip;
        logic        negz;
        logic [63:0] mag;
        longint      x, y, z, xn;
        flip = 0;
        if (deg > 900000000) begin
            deg -= 1800000000;
            flip = 1;
        end else if (deg < -900000000) begin
            deg += 1800000000;
            flip = 1;
        end
        negz = deg < 0;
        mag  = negz ? -deg : deg;
        z    = longint'((mag * DEG_TO_RAD + 64'h40000000) >> 31);
        if (negz) z = -z;
        x = ROT_START;
        y = 0;
        for (int i = 0; i < N_STAGES; i++) begin
            if (z >= 0) begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z -= atan_tab[i];
            end else begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z += atan_tab[i];
            end
            x = xn;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= res + bitv) begin
                v  -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint central_angle(longint num, longint den);
        longint x, y, z, xn;
        if (num == 0) return (den < 0) ? ARC_PI : 0;
        x = den;
        y = num;
        z = 0;
        // start from a quarter turn when the dot term is negative
        if (x < 0) begin
            x = num;
            y = -den;
            z = ARC_HALFPI;
        end
        for (int i = 0; i < N_STAGES; i++) begin
            if (y > 0) begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z += atan_tab[i];
            end else begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z -= atan_tab[i];
            end
            x = xn;
        end
        return z;
    endfunction

    function automatic logic [24:0] surface_distance(longint la, longint oa, longint lb,
                                                     longint ob);
        longint      dl, s1, c1, s2, c2, sd, cd, t1, t2, den, ang;
        logic [63:0] m1, m2, num, dist_m;
        dl = oa - ob;
        if (dl > 1800000000) dl -= 64'sd3600000000;
        else if (dl <= -1800000000) dl += 64'sd3600000000;
        trig_of(la, s1, c1);
        trig_of(lb, s2, c2);
        trig_of(dl, sd, cd);
        t1  = mul_q30(c1, s2) - mul_q30(mul_q30(s1, c2), cd);
        t2  = mul_q30(c2, sd);
        den = mul_q30(s1, s2) + mul_q30(mul_q30(c1, c2), cd);
        m1  = (t1 < 0) ? -t1 : t1;
        m2  = (t2 < 0) ? -t2 : t2;
        num = floor_root(m1 * m1 + m2 * m2);
        ang = central_angle(longint'(num), den);
        if (ang < 0) ang = 0;
        dist_m = (64'(ang) * RADIUS_M + 64'h20000000) >> 30;
        if (dist_m > HALF_EARTH) dist_m = HALF_EARTH;
        return dist_m[24:0];
    endfunction

    assign o_pending = distance_q.size();

    always @(posedge i_clk) begin
        logic [24:0] want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                distance_q = {distance_q,
                              surface_distance(i_lat_a, i_lon_a, i_lat_b, i_lon_b)};
            if (i_out_valid && i_out_ready) begin
                if (distance_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected distance beat %0d", i_distance_m);
                end else begin
                    want = distance_q.pop_front();
                    if (want !== i_distance_m) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("distance mismatch: expected %0d, got %0d",
                                     want, i_distance_m);
                    end
                end
            end
        end
    end

endmodule

>>> test/tb_great_circle_distance.sv
`timescale 1ns / 100ps
// Testbench top for great_circle_distance: drives position pairs with random gaps and
// back-pressure, and gives the verdict. Depends on gcd_checker and the block itself.
module tb_great_circle_distance;

    localparam int N_RANDOM  = 1500;
    localparam int LATENCY   = 104;
    localparam int LONG_HOLD = 400;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    logic               out_valid;
    logic               out_ready;
    logic [24:0]        distance_m;
    int                 fail_count;
    int                 pending;
    logic               stim_done;

    great_circle_distance u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_lat_a      (lat_a),
        .i_lon_a      (lon_a),
        .i_lat_b      (lat_b),
        .i_lon_b      (lon_b),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_distance_m (distance_m)
    );

    gcd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_lat_a      (lat_a),
        .i_lon_a      (lon_a),
        .i_lat_b      (lat_b),
        .i_lon_b      (lon_b),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_distance_m (distance_m),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Draw a gap per beat; some stretches run back to back.
    function automatic int draw_gap(int idx);
        if ((idx % 400) < 80) return 0;
        return $urandom_range(19, 0);
    endfunction

    // Offer one beat after the given gap and hold it until accepted.
    // Entered and left on a falling edge.
    task automatic send_pair(int gap, logic signed [30:0] la, logic signed [31:0] oa,
                             logic signed [30:0] lb, logic signed [31:0] ob);
        if (gap > 0) begin
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1;
        lat_a    = la;
        lon_a    = oa;
        lat_b    = lb;
        lon_b    = ob;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Mostly positions in range, sometimes any 31/32-bit value so every bit toggles.
    function automatic logic signed [30:0] rand_lat();
        if ($urandom_range(9, 0) == 0) return 31'($urandom);
        return 31'($signed($urandom_range(1800000000, 0)) - 900000000);
    endfunction

    function automatic logic signed [31:0] rand_lon();
        if ($urandom_range(9, 0) == 0) return 32'($urandom);
        return 32'($urandom_range(32'd3600000000, 0) - 64'd1800000000);
    endfunction

    // sender
    initial begin
        logic signed [30:0] la, lb;
        logic signed [31:0] oa;
        in_valid  = 0;
        lat_a     = 0;
        lon_a     = 0;
        lat_b     = 0;
        lon_b     = 0;
        stim_done = 0;
        rst_n     = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: same point, antipodes, poles, date line, field extremes
        send_pair(0, 0, 0, 0, 0);
        send_pair(1, 0, 0, 0, 1800000000);
        send_pair(0, 0, 0, 0, -1800000000);
        send_pair(2, 900000000, 0, -900000000, 0);
        send_pair(0, 900000000, 123, 900000000, -77);
        send_pair(0, -900000000, 0, -900000000, 1800000000);
        send_pair(3, 900000000, 0, 900000000 - 1, 0);
        send_pair(0, 0, 1799999999, 0, -1799999999);
        send_pair(0, 0, -1800000000, 0, 1800000000);
        send_pair(0, 515000000, -1200000, -515000000, 1788000000);
        send_pair(1, 31'sh3FFFFFFF, 32'sh7FFFFFFF, -31'sh40000000, -32'sh80000000);
        send_pair(0, -31'sh40000000, -32'sh80000000, 31'sh3FFFFFFF, 32'sh7FFFFFFF);
        send_pair(0, 31'sh3FFFFFFF, 0, 31'sh3FFFFFFF, 0);
        send_pair(0, 450000000, 450000000, -450000000, -1350000000);
        send_pair(0, 1, 1, 0, 0);
        send_pair(2, -1, -1, 1, 1);
        send_pair(0, 400000000, 900000000, 400000000, -900000000);
        send_pair(0, 0, 900000000, 0, -900000000);
        send_pair(0, 899999999, 0, -899999999, 1800000000);
        send_pair(0, 123456789, 987654321, 123456789, 987654321);

        for (int k = 0; k < N_RANDOM; k++) begin
            la = rand_lat();
            oa = rand_lon();
            case ($urandom_range(7, 0))
                0: send_pair(draw_gap(k), la, oa, la, oa);                    // same point
                1: send_pair(draw_gap(k), la, oa, -la, oa + 32'sd1800000000); // antipode
                2: begin                                                      // near neighbor
                    lb = la + 31'($signed($urandom_range(2000, 0)) - 1000);
                    send_pair(draw_gap(k), la, oa, lb,
                              oa + 32'($signed($urandom_range(2000, 0)) - 1000));
                end
                default: send_pair(draw_gap(k), la, oa, rand_lat(), rand_lon());
            endcase
        end
        in_valid  = 0;
        stim_done = 1;
    end

    // receiver: random stalls, one long hold-off so the pipeline fills and stalls input
    initial begin
        int beats;
        int gap;
        beats     = 0;
        out_ready = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            gap = (beats == 200) ? LONG_HOLD : draw_gap(beats + 150);
            if (gap > 0) begin
                out_ready = 0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1;
            do @(posedge clk); while (!out_valid);
            beats++;
            @(negedge clk);
        end
    end

    // verdict
    initial begin
        @(posedge stim_done);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("great_circle_distance regression: pass");
        else
            $display("great_circle_distance regression: fail");
        $finish;
    end

    // hard limit on run time
    initial begin
        #4ms;
        $display("great_circle_distance regression: fail");
        $finish;
    end

endmodule
